>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared macros for the concurrent checks of the key combo detector.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression must hold at every clock edge outside reset.
`define KCLP_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) \
        else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define KCLP_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define KCLP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

>>> design/kclp_pkg.sv
// ----------------------------------------------------------------------------
// kclp_pkg
// Types, codes and reset values shared by the key combo detector modules.
// ----------------------------------------------------------------------------
`default_nettype none

package kclp_pkg;

    localparam int SEQ_MAX_DEF    = 6;
    localparam int TIMER_BITS_DEF = 16;

    localparam int SEQ_SLOTS  = 6;
    localparam int CODE_W     = 10;
    localparam int VALUE_W    = 2;
    localparam int LEN_W      = 3;
    localparam int TIMEOUT_W  = 16;
    localparam int SEQ_W      = SEQ_SLOTS * CODE_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = SEQ_W;

    localparam logic [CODE_W-1:0] CODE_VOL_DOWN = 10'd114;
    localparam logic [CODE_W-1:0] CODE_VOL_UP   = 10'd115;
    localparam logic [CODE_W-1:0] CODE_POWER    = 10'd116;
    localparam logic [CODE_W-1:0] CODE_MENU     = 10'd139;

    localparam logic [VALUE_W-1:0] VAL_RELEASE = 2'd0;
    localparam logic [VALUE_W-1:0] VAL_PRESS   = 2'd1;

    localparam logic [CFG_IDX_W-1:0] REG_SEQ_CODES  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SEQ_LENGTH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ACC_REPEAT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_CODE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_VALUE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_TIME  = 3'd5;

    localparam logic [LEN_W-1:0]     RST_SEQ_LENGTH = 3'd1;
    localparam logic [CODE_W-1:0]    RST_HOLD_CODE  = 10'd116;
    localparam logic [VALUE_W-1:0]   RST_HOLD_VALUE = 2'd1;
    localparam logic [TIMEOUT_W-1:0] RST_HOLD_TIME  = 16'd5000;

    typedef struct packed {
        logic               op;
        logic               is_key_event;
        logic [CODE_W-1:0]  key_code;
        logic [VALUE_W-1:0] key_value;
    } in_t;

    typedef struct packed {
        logic             sequence_hit;
        logic             long_press_hit;
        logic             hold_armed;
        logic [LEN_W-1:0] match_progress;
    } out_t;

    typedef struct packed {
        logic [SEQ_W-1:0]     sequence_codes;
        logic [LEN_W-1:0]     sequence_length;
        logic                 accept_repeat;
        logic [CODE_W-1:0]    hold_key_code;
        logic [VALUE_W-1:0]   hold_key_value;
        logic [TIMEOUT_W-1:0] hold_timeout_ticks;
    } cfg_t;

    typedef struct packed {
        logic               is_tick;
        logic               key_hit;
        logic [CODE_W-1:0]  key_code;
        logic [VALUE_W-1:0] key_value;
    } ev_t;

    function automatic logic [CODE_W-1:0] seq_code(input logic [SEQ_W-1:0] codes,
                                                   input logic [LEN_W-1:0] idx);
        logic [CODE_W-1:0] code;
        unique case (idx)
            3'd0: code = codes[0*CODE_W +: CODE_W];
            3'd1: code = codes[1*CODE_W +: CODE_W];
            3'd2: code = codes[2*CODE_W +: CODE_W];
            3'd3: code = codes[3*CODE_W +: CODE_W];
            3'd4: code = codes[4*CODE_W +: CODE_W];
            3'd5: code = codes[5*CODE_W +: CODE_W];
            default: code = '0;
        endcase
        return code;
    endfunction

    function automatic logic is_watched(input logic [CODE_W-1:0] code);
        return (code == CODE_VOL_DOWN) || (code == CODE_VOL_UP) ||
               (code == CODE_POWER) || (code == CODE_MENU);
    endfunction

endpackage

`default_nettype wire

>>> design/kclp_combo.sv
// ----------------------------------------------------------------------------
// kclp_combo
// Key sequence matcher that restarts on the first code of the sequence.
// ----------------------------------------------------------------------------
`default_nettype none

module kclp_combo #(
    parameter int SEQ_MAX = kclp_pkg::SEQ_MAX_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        advance,
    input  kclp_pkg::ev_t               ev,
    input  kclp_pkg::cfg_t              cfg,
    output logic                        seq_hit,
    output logic [kclp_pkg::LEN_W-1:0]  match_next
);

    localparam logic [kclp_pkg::LEN_W-1:0] SEQ_MAX_L = kclp_pkg::LEN_W'(SEQ_MAX);

    logic [kclp_pkg::LEN_W-1:0]   match_reg;
    logic [kclp_pkg::LEN_W-1:0]   eff_len;
    logic [kclp_pkg::VALUE_W-1:0] value_mask;
    logic                         step;

    assign value_mask = {cfg.accept_repeat, 1'b1};
    assign step       = ev.key_hit && ((ev.key_value & value_mask) != '0);

    always_comb begin
        if (cfg.sequence_length == '0) begin
            eff_len = 3'd1;
        end else if (cfg.sequence_length > SEQ_MAX_L) begin
            eff_len = SEQ_MAX_L;
        end else begin
            eff_len = cfg.sequence_length;
        end
    end

    always_comb begin
        match_next = match_reg;
        seq_hit    = 1'b0;
        if (step) begin
            if (match_reg >= eff_len) begin
                match_next = '0;
            end else if (kclp_pkg::seq_code(cfg.sequence_codes, match_reg) == ev.key_code) begin
                if ((match_reg + 3'd1) >= eff_len) begin
                    match_next = '0;
                    seq_hit    = 1'b1;
                end else begin
                    match_next = match_reg + 3'd1;
                end
            end else if (kclp_pkg::seq_code(cfg.sequence_codes, 3'd0) == ev.key_code) begin
                match_next = 3'd1;
            end else begin
                match_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            match_reg <= '0;
        end else if (advance) begin
            match_reg <= match_next;
        end
    end

endmodule

`default_nettype wire

>>> design/kclp_hold.sv
// ----------------------------------------------------------------------------
// kclp_hold
// Long-press watcher with its arming flags and hold countdown.
// ----------------------------------------------------------------------------
`default_nettype none

module kclp_hold #(
    parameter int TIMER_BITS = kclp_pkg::TIMER_BITS_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           advance,
    input  kclp_pkg::ev_t  ev,
    input  kclp_pkg::cfg_t cfg,
    output logic           long_hit,
    output logic           armed_next
);

    localparam int LW = (TIMER_BITS > kclp_pkg::TIMEOUT_W) ? TIMER_BITS : kclp_pkg::TIMEOUT_W;
    localparam logic [LW-1:0] TMAX = (LW'(1) << TIMER_BITS) - LW'(1);

    logic                  armed_reg;
    logic                  fpp_reg;
    logic                  frp_reg;
    logic                  run_reg;
    logic [TIMER_BITS-1:0] cd_reg;
    logic                  fpp_next;
    logic                  frp_next;
    logic                  run_next;
    logic [TIMER_BITS-1:0] cd_next;
    logic [TIMER_BITS-1:0] cd_dec;
    logic [LW-1:0]         t_ext;
    logic [LW-1:0]         t_sat;
    logic                  is_power;

    assign t_ext    = LW'(cfg.hold_timeout_ticks);
    assign cd_dec   = cd_reg - TIMER_BITS'(1);
    assign is_power = (ev.key_code == kclp_pkg::CODE_POWER);

    always_comb begin
        if (t_ext == '0) begin
            t_sat = LW'(1);
        end else if (t_ext > TMAX) begin
            t_sat = TMAX;
        end else begin
            t_sat = t_ext;
        end
    end

    always_comb begin
        armed_next = armed_reg;
        fpp_next   = fpp_reg;
        frp_next   = frp_reg;
        run_next   = run_reg;
        cd_next    = cd_reg;
        long_hit   = 1'b0;
        if (ev.is_tick) begin
            if (run_reg) begin
                cd_next = cd_dec;
                if (cd_dec == '0) begin
                    run_next = 1'b0;
                    long_hit = armed_reg;
                end
            end
        end else if (ev.key_hit && armed_reg) begin
            if (is_power && fpp_reg && (ev.key_value == kclp_pkg::VAL_PRESS)) begin
                fpp_next = 1'b0;
            end else if (is_power && frp_reg && (ev.key_value == kclp_pkg::VAL_RELEASE)) begin
                frp_next = 1'b0;
            end else if ((ev.key_code != cfg.hold_key_code) ||
                         (ev.key_value != cfg.hold_key_value)) begin
                armed_next = 1'b0;
            end else begin
                cd_next  = TIMER_BITS'(t_sat);
                run_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            armed_reg <= 1'b1;
            fpp_reg   <= 1'b1;
            frp_reg   <= 1'b1;
            run_reg   <= 1'b0;
            cd_reg    <= '0;
        end else if (advance) begin
            armed_reg <= armed_next;
            fpp_reg   <= fpp_next;
            frp_reg   <= frp_next;
            run_reg   <= run_next;
            cd_reg    <= cd_next;
        end
    end

endmodule

`default_nettype wire

>>> design/key_combo_and_long_press_detector_unit.sv
// ----------------------------------------------------------------------------
// key_combo_and_long_press_detector_unit
// Key combo matcher and long-press watcher fed by key events and timer ticks.
// ----------------------------------------------------------------------------
// Every request, whether a key event or a tick, produces exactly one result.
// A request is captured in an input register and its result is offered from
// a result register, so the block accepts one request per clock while the
// output side is not stalled. Configuration writes take effect at once and
// must be made while no request is in flight.
`default_nettype none

module key_combo_and_long_press_detector_unit #(
    parameter int SEQ_MAX    = kclp_pkg::SEQ_MAX_DEF,
    parameter int TIMER_BITS = kclp_pkg::TIMER_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  kclp_pkg::in_t                    s_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output kclp_pkg::out_t                   m_data,
    input  logic                             cfg_wr_en,
    input  logic [kclp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [kclp_pkg::CFG_DATA_W-1:0]  cfg_data
);

    kclp_pkg::cfg_t cfg_reg;
    kclp_pkg::in_t  in_data_reg;
    kclp_pkg::out_t out_data_reg;
    kclp_pkg::out_t result;
    kclp_pkg::ev_t  ev;
    logic           in_valid_reg;
    logic           out_valid_reg;
    logic           advance;
    logic           seq_hit;
    logic           long_hit;
    logic           armed_next;
    logic [kclp_pkg::LEN_W-1:0] match_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.sequence_codes     <= '0;
            cfg_reg.sequence_length    <= kclp_pkg::RST_SEQ_LENGTH;
            cfg_reg.accept_repeat      <= 1'b0;
            cfg_reg.hold_key_code      <= kclp_pkg::RST_HOLD_CODE;
            cfg_reg.hold_key_value     <= kclp_pkg::RST_HOLD_VALUE;
            cfg_reg.hold_timeout_ticks <= kclp_pkg::RST_HOLD_TIME;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                kclp_pkg::REG_SEQ_CODES: begin
                    cfg_reg.sequence_codes <= cfg_data[kclp_pkg::SEQ_W-1:0];
                end
                kclp_pkg::REG_SEQ_LENGTH: begin
                    cfg_reg.sequence_length <= cfg_data[kclp_pkg::LEN_W-1:0];
                end
                kclp_pkg::REG_ACC_REPEAT: begin
                    cfg_reg.accept_repeat <= cfg_data[0];
                end
                kclp_pkg::REG_HOLD_CODE: begin
                    cfg_reg.hold_key_code <= cfg_data[kclp_pkg::CODE_W-1:0];
                end
                kclp_pkg::REG_HOLD_VALUE: begin
                    cfg_reg.hold_key_value <= cfg_data[kclp_pkg::VALUE_W-1:0];
                end
                kclp_pkg::REG_HOLD_TIME: begin
                    cfg_reg.hold_timeout_ticks <= cfg_data[kclp_pkg::TIMEOUT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
    end

    assign ev.is_tick   = in_data_reg.op;
    assign ev.key_hit   = !in_data_reg.op && in_data_reg.is_key_event &&
                          kclp_pkg::is_watched(in_data_reg.key_code);
    assign ev.key_code  = in_data_reg.key_code;
    assign ev.key_value = in_data_reg.key_value;

    kclp_combo #(
        .SEQ_MAX    (SEQ_MAX)
    ) u_combo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .advance    (advance),
        .ev         (ev),
        .cfg        (cfg_reg),
        .seq_hit    (seq_hit),
        .match_next (match_next)
    );

    kclp_hold #(
        .TIMER_BITS (TIMER_BITS)
    ) u_hold (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .advance    (advance),
        .ev         (ev),
        .cfg        (cfg_reg),
        .long_hit   (long_hit),
        .armed_next (armed_next)
    );

    assign result.sequence_hit   = seq_hit;
    assign result.long_press_hit = long_hit;
    assign result.hold_armed     = armed_next;
    assign result.match_progress = match_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

`default_nettype wire

>>> design/kclp_checker.sv
// ----------------------------------------------------------------------------
// kclp_checker
// Port-level checks for the key combo detector, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module kclp_checker (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             m_valid,
    input  logic                             m_ready,
    input  kclp_pkg::out_t                   m_data
);

    // A stalled result keeps its payload until it is taken.
    `KCLP_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_data), "stall broken")

    // A request is either a key event or a tick, so it cannot raise both hits.
    `KCLP_ASSERT_IMPL(a_one_hit, m_valid, !(m_data.sequence_hit && m_data.long_press_hit), "two hits")

    // Progress wraps to zero on a full match and never reaches the slot count.
    `KCLP_ASSERT_IMPL(a_progress, m_valid, m_data.match_progress < 3'd6, "bad progress")

    // A long press is reported only while the watcher is armed.
    `KCLP_ASSERT_IMPL(a_long_armed, m_valid && m_data.long_press_hit, m_data.hold_armed, "disarmed hit")

endmodule

bind key_combo_and_long_press_detector_unit kclp_checker u_kclp_checker (.*);

`default_nettype wire
